@@ rtl/per_user_job_quota_table_assert.svh @@
// ----------------------------------------------------------------------------
// per_user_job_quota_table_assert
// assertion macros used by the quota table checks
// ----------------------------------------------------------------------------
`ifndef PER_USER_JOB_QUOTA_TABLE_ASSERT_SVH
`define PER_USER_JOB_QUOTA_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define QTAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define QTAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/qtab_pkg.sv @@
// ----------------------------------------------------------------------------
// qtab_pkg
// types and constants of the per-user job quota table
// ----------------------------------------------------------------------------
package qtab_pkg;

    localparam int USER_ENTRIES = 64;
    localparam int KEY_BITS     = 32;
    localparam int CNT_W        = 32;
    localparam int IDX_W        = $clog2(USER_ENTRIES);
    localparam int FILL_W       = $clog2(USER_ENTRIES + 1);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        REQ_CHECK      = 2'd0,
        REQ_REGISTER   = 2'd1,
        REQ_UNREGISTER = 2'd2,
        REQ_COUNT      = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_LIMIT   = 3'd1,
        ST_ZERO    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [CNT_W-1:0]    cnt;
    } t_entry;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] raddr;
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
    } t_ram_req;

endpackage

@@ rtl/qtab_store.sv @@
// ----------------------------------------------------------------------------
// qtab_store
// entry memory: key and job count per user, one write and one read port
// ----------------------------------------------------------------------------
module qtab_store (
    input  logic               i_clk,
    input  qtab_pkg::t_ram_req i_req,
    output qtab_pkg::t_entry   o_rdata
);

    qtab_pkg::t_entry r_mem [qtab_pkg::USER_ENTRIES];
    qtab_pkg::t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/per_user_job_quota_table.sv @@
// ----------------------------------------------------------------------------
// per_user_job_quota_table
// per-user job admission table with quota check and job counting
// ----------------------------------------------------------------------------
// Each request item (check, register, unregister, count) is handled alone:
// the key is searched by reading the entry memory one entry per cycle from
// entry 0 up to the last occupied entry, then the decide state updates the
// count and loads the result register; the entry memory has a single read
// port. A stalled result holds the decide state of the following item until
// it is taken. Entries fill from 0 upward and are never freed, so a fill
// count stands for the valid bits and no clearing pass is needed after
// reset. The result register lets the next item be accepted while a result
// waits.
// ----------------------------------------------------------------------------
module per_user_job_quota_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    // request items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_user_key,
    input  logic        i_force_req,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_job_count
);

    localparam int IDX_W  = qtab_pkg::IDX_W;
    localparam int FILL_W = qtab_pkg::FILL_W;
    localparam int CNT_W  = qtab_pkg::CNT_W;

    qtab_pkg::t_state              r_state, n_state;
    logic [CNT_W-1:0]              r_max_jobs;
    logic [FILL_W-1:0]             r_fill;
    qtab_pkg::t_req                r_req;
    logic [qtab_pkg::KEY_BITS-1:0] r_key;
    logic                          r_force;
    logic [IDX_W-1:0]              r_addr;
    logic [IDX_W-1:0]              r_rd_addr;
    logic                          r_rd_vld;
    logic                          r_found;
    logic [IDX_W-1:0]              r_idx;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_out_valid;
    qtab_pkg::t_status             r_status;
    logic [CNT_W-1:0]              r_job_count;

    qtab_pkg::t_ram_req            ram_req;
    qtab_pkg::t_entry              ram_rdata;

    logic                          in_acc;
    logic                          out_free;
    logic [FILL_W-1:0]             fill_m1;
    logic                          rd_last;
    logic                          rd_hit;
    logic                          tbl_full;
    logic                          grant;
    logic                          add_new;
    logic                          upd_cnt;
    logic [CNT_W-1:0]              new_cnt;
    qtab_pkg::t_status             d_status;
    logic [CNT_W-1:0]              d_count;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign fill_m1  = r_fill - FILL_W'(1);
    assign rd_last  = (FILL_W'(r_rd_addr) == fill_m1);
    assign rd_hit   = r_rd_vld && (ram_rdata.key == r_key);
    assign tbl_full = (r_fill == FILL_W'(qtab_pkg::USER_ENTRIES));

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_jobs <= '0;
        end else if (i_cfg_we) begin
            r_max_jobs <= i_cfg_wdata;
        end
    end

    // decide: status, count and write-back for the searched entry
    always_comb begin
        grant    = (r_max_jobs == '0) || r_force || (r_cnt < r_max_jobs);
        add_new  = 1'b0;
        upd_cnt  = 1'b0;
        new_cnt  = r_cnt;
        d_status = qtab_pkg::ST_OK;
        d_count  = '0;
        unique case (r_req)
            qtab_pkg::REQ_CHECK, qtab_pkg::REQ_REGISTER: begin
                if (!r_found) begin
                    if (tbl_full) begin
                        d_status = qtab_pkg::ST_FULL;
                    end else begin
                        // new user starts at zero, which always passes the limit
                        add_new = 1'b1;
                        new_cnt = (r_req == qtab_pkg::REQ_REGISTER) ? CNT_W'(1) : '0;
                        d_count = new_cnt;
                    end
                end else if (grant) begin
                    if ((r_req == qtab_pkg::REQ_REGISTER) && (r_cnt != qtab_pkg::CNT_MAX)) begin
                        upd_cnt = 1'b1;
                        new_cnt = r_cnt + CNT_W'(1);
                    end
                    d_count = new_cnt;
                end else begin
                    d_status = qtab_pkg::ST_LIMIT;
                    d_count  = r_cnt;
                end
            end
            qtab_pkg::REQ_UNREGISTER: begin
                if (!r_found) begin
                    d_status = qtab_pkg::ST_UNKNOWN;
                end else if (r_cnt == '0) begin
                    d_status = qtab_pkg::ST_ZERO;
                end else begin
                    upd_cnt = 1'b1;
                    new_cnt = r_cnt - CNT_W'(1);
                    d_count = new_cnt;
                end
            end
            qtab_pkg::REQ_COUNT: begin
                d_count = r_found ? r_cnt : '0;
            end
            default: begin
                d_status = qtab_pkg::ST_OK;
            end
        endcase
    end

    // memory access: scan reads, decide writes back
    always_comb begin
        ram_req.re        = (r_state == qtab_pkg::S_SCAN);
        ram_req.raddr     = r_addr;
        ram_req.we        = (r_state == qtab_pkg::S_DECIDE) && out_free && (add_new || upd_cnt);
        ram_req.waddr     = add_new ? r_fill[IDX_W-1:0] : r_idx;
        ram_req.wdata.key = r_key;
        ram_req.wdata.cnt = new_cnt;
    end

    qtab_store u_store (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != qtab_pkg::S_IDLE);
        unique case (r_state)
            qtab_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (r_fill == '0) ? qtab_pkg::S_DECIDE : qtab_pkg::S_SCAN;
                end
            end
            qtab_pkg::S_SCAN: begin
                if (rd_hit || (r_rd_vld && rd_last)) begin
                    n_state = qtab_pkg::S_DECIDE;
                end
            end
            qtab_pkg::S_DECIDE: begin
                if (out_free) begin
                    n_state = qtab_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qtab_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qtab_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // read pipeline tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == qtab_pkg::S_SCAN) && !rd_hit && !(r_rd_vld && rd_last);
        end
    end

    // item capture, scan address and search result
    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_addr;
        if (in_acc) begin
            r_req   <= qtab_pkg::t_req'(i_req_type);
            r_key   <= i_user_key[qtab_pkg::KEY_BITS-1:0];
            r_force <= i_force_req;
            r_found <= 1'b0;
            r_addr  <= '0;
        end else if (r_state == qtab_pkg::S_SCAN) begin
            if (FILL_W'(r_addr) != fill_m1) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (rd_hit) begin
                r_found <= 1'b1;
                r_idx   <= r_rd_addr;
                r_cnt   <= ram_rdata.cnt;
            end
        end
    end

    // fill count of occupied entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if ((r_state == qtab_pkg::S_DECIDE) && out_free && add_new) begin
            r_fill <= r_fill + FILL_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == qtab_pkg::S_DECIDE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == qtab_pkg::S_DECIDE) && out_free) begin
            r_status    <= d_status;
            r_job_count <= d_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_job_count = r_job_count;

    // checks
`include "per_user_job_quota_table_assert.svh"

    `QTAB_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= FILL_W'(qtab_pkg::USER_ENTRIES), "fill count over table size")
    `QTAB_ASSERT_NEXT(a_accept_busy, in_acc, r_state != qtab_pkg::S_IDLE, "accepted item did not start")
    `QTAB_ASSERT_NOW(a_fill_step, $past(i_rst_n) && (r_fill != $past(r_fill)), r_fill == $past(r_fill) + FILL_W'(1), "fill count jumped")
    `QTAB_ASSERT_NOW(a_write_decide, ram_req.we, r_state == qtab_pkg::S_DECIDE && !tbl_full || upd_cnt, "entry write outside decide")

endmodule

@@ sim/per_user_job_quota_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_user_job_quota_table_tb
// self-checking bench for the per-user job quota table
// ----------------------------------------------------------------------------
// Request items come from a queue that the stimulus block fills phase by
// phase. A clocked driver presents them with random gaps. Each accepted item
// runs through a local admission predictor, and the answer it gives is
// queued. A clocked monitor stalls at random and compares every result item
// with the oldest queued answer. The job limit changes only between phases,
// once every answer has arrived. The run covers zero, small, large and
// random limits, forced admission, count underflow, unknown users and a
// full table.
// ----------------------------------------------------------------------------
module per_user_job_quota_table_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_SIZE   = 40;
    localparam int HOT_SIZE    = 6;
    localparam int PHASE_ITEMS = 170;

    typedef struct packed {
        qtab_pkg::t_req req;
        logic [31:0]    key;
        logic           frc;
    } t_job_req;

    typedef struct packed {
        qtab_pkg::t_status st;
        logic [31:0]       cnt;
    } t_job_ans;

    // block ports
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           cfg_we    = 1'b0;
    logic [31:0]    cfg_wdata = '0;
    logic           in_valid  = 1'b0;
    logic           in_stall;
    qtab_pkg::t_req req_type  = qtab_pkg::REQ_CHECK;
    logic [31:0]    user_key  = '0;
    logic           force_req = 1'b0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    logic [2:0]     status;
    logic [31:0]    job_count;

    // bench state
    t_job_req    pending_reqs[$];
    t_job_ans    due_answers[$];
    t_job_req    acc_item;
    logic        acc_fire  = 1'b0;
    int          send_gap  = 0;
    int          rx_hold   = 0;
    logic        calm      = 1'b0;
    int          hot_base  = 0;
    int          fails     = 0;
    int          cycle_cnt = 0;
    int          limit_settings = 0;
    int          req_seen[4];
    int          status_seen[8];
    logic [31:0] key_pool[POOL_SIZE];

    // predictor copy of the table and the limit
    logic                          user_live[qtab_pkg::USER_ENTRIES];
    logic [qtab_pkg::KEY_BITS-1:0] user_id[qtab_pkg::USER_ENTRIES];
    logic [qtab_pkg::CNT_W-1:0]    user_jobs[qtab_pkg::USER_ENTRIES];
    logic [31:0]                   quota_limit = '0;

    per_user_job_quota_table uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_user_key  (user_key),
        .i_force_req (force_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_status    (status),
        .o_job_count (job_count)
    );

    // clock
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // lowest live entry holding the key, -1 if none
    function automatic int lookup_user(logic [qtab_pkg::KEY_BITS-1:0] k);
        for (int i = 0; i < qtab_pkg::USER_ENTRIES; i++)
            if (user_live[i] && user_id[i] == k)
                return i;
        return -1;
    endfunction

    // admission decision and table update for one request item
    function automatic t_job_ans admit_request(t_job_req rq);
        t_job_ans res;
        int       slot;
        res.st  = qtab_pkg::ST_OK;
        res.cnt = '0;
        slot    = lookup_user(rq.key[qtab_pkg::KEY_BITS-1:0]);
        case (rq.req)
            qtab_pkg::REQ_CHECK, qtab_pkg::REQ_REGISTER: begin
                // unknown user takes the lowest free entry
                for (int i = 0; i < qtab_pkg::USER_ENTRIES && slot < 0; i++)
                    if (!user_live[i]) begin
                        slot         = i;
                        user_live[i] = 1'b1;
                        user_id[i]   = rq.key[qtab_pkg::KEY_BITS-1:0];
                        user_jobs[i] = '0;
                    end
                if (slot < 0) begin
                    res.st = qtab_pkg::ST_FULL;
                end else begin
                    res.cnt = user_jobs[slot];
                    if (quota_limit == '0 || rq.frc || res.cnt < quota_limit) begin
                        // count saturates at its maximum
                        if (rq.req == qtab_pkg::REQ_REGISTER &&
                            res.cnt != qtab_pkg::CNT_MAX) begin
                            res.cnt         = res.cnt + 1'b1;
                            user_jobs[slot] = res.cnt;
                        end
                    end else begin
                        res.st = qtab_pkg::ST_LIMIT;
                    end
                end
            end
            qtab_pkg::REQ_UNREGISTER: begin
                if (slot < 0)
                    res.st = qtab_pkg::ST_UNKNOWN;
                else if (user_jobs[slot] == '0)
                    res.st = qtab_pkg::ST_ZERO;
                else begin
                    res.cnt         = user_jobs[slot] - 1'b1;
                    user_jobs[slot] = res.cnt;
                end
            end
            default: begin
                if (slot >= 0)
                    res.cnt = user_jobs[slot];
            end
        endcase
        return res;
    endfunction

    // request driver
    always @(posedge clk) begin
        int       gap;
        logic     take;
        logic     drive;
        t_job_req nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
            acc_fire <= 1'b0;
        end else begin
            take  = in_valid && !in_stall;
            drive = in_valid && !take;
            gap   = take ? draw_wait() : send_gap;
            if (!drive) begin
                if (gap != 0) begin
                    gap = gap - 1;
                end else if (pending_reqs.size() != 0) begin
                    nxt       = pending_reqs.pop_front();
                    req_type  <= nxt.req;
                    user_key  <= nxt.key;
                    force_req <= nxt.frc;
                    drive     = 1'b1;
                end
            end
            acc_fire <= take;
            acc_item <= '{req: req_type, key: user_key, frc: force_req};
            in_valid <= drive;
            send_gap <= gap;
        end
    end

    // answer for the item taken at the last rising edge
    always @(negedge clk) begin
        if (acc_fire) begin
            req_seen[acc_item.req] = req_seen[acc_item.req] + 1;
            due_answers.push_back(admit_request(acc_item));
        end
    end

    // result monitor
    always @(posedge clk) begin
        int       hold;
        t_job_ans want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            rx_hold   <= 0;
        end else begin
            hold = rx_hold;
            if (out_valid && !out_stall) begin
                if (due_answers.size() == 0) begin
                    $error("result item with no answer pending: status %0d, job_count %0d",
                           status, job_count);
                    fails = fails + 1;
                end else begin
                    want = due_answers.pop_front();
                    if (status !== want.st) begin
                        $error("status: expected %0d, actual %0d", want.st, status);
                        fails = fails + 1;
                    end
                    if (job_count !== want.cnt) begin
                        $error("job_count: expected %0d, actual %0d", want.cnt, job_count);
                        fails = fails + 1;
                    end
                end
                status_seen[status] = status_seen[status] + 1;
                hold = draw_wait();
            end else if (hold != 0) begin
                hold = hold - 1;
            end
            rx_hold   <= hold;
            out_stall <= (hold != 0);
        end
    end

    task automatic push_req(qtab_pkg::t_req req, logic [31:0] key, logic frc);
        pending_reqs.push_back('{req: req, key: key, frc: frc});
    endtask

    // wait until every item is taken and every result has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || acc_fire || due_answers.size() != 0);
    endtask

    task automatic set_limit(logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we      <= 1'b0;
        quota_limit = v;
        limit_settings = limit_settings + 1;
        @(negedge clk);
    endtask

    // mostly a few hot users so counts climb to the limit, some fresh keys
    task automatic push_random(int n);
        int             r;
        int             k;
        qtab_pkg::t_req rq;
        logic [31:0]    key;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 60)
                key = key_pool[hot_base + $urandom_range(0, HOT_SIZE - 1)];
            else if (k < 93)
                key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                key = $urandom;
            r = $urandom_range(0, 99);
            if (r < 40)
                rq = qtab_pkg::REQ_REGISTER;
            else if (r < 65)
                rq = qtab_pkg::REQ_UNREGISTER;
            else if (r < 80)
                rq = qtab_pkg::REQ_CHECK;
            else
                rq = qtab_pkg::REQ_COUNT;
            push_req(rq, key, $urandom_range(0, 4) == 0);
        end
    endtask

    // stimulus
    initial begin
        logic [31:0] limits[7];
        logic [31:0] fresh;
        int          users;
        limits = '{32'd0, 32'd3, 32'hFFFF_FFFF, 32'd2, 32'd0, 32'd1, 32'd5};
        limits[4] = $urandom;
        for (int i = 0; i < qtab_pkg::USER_ENTRIES; i++) begin
            user_live[i] = 1'b0;
            user_id[i]   = '0;
            user_jobs[i] = '0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'hAAAA_AAAA;
        key_pool[3] = 32'h5555_5555;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: limit of one, unknown user, limit hit, force, underflow
        set_limit(32'd1);
        push_req(qtab_pkg::REQ_COUNT,      key_pool[0], 1'b0);
        push_req(qtab_pkg::REQ_UNREGISTER, key_pool[0], 1'b1);
        push_req(qtab_pkg::REQ_CHECK,      key_pool[0], 1'b0);
        push_req(qtab_pkg::REQ_REGISTER,   key_pool[0], 1'b0);
        push_req(qtab_pkg::REQ_REGISTER,   key_pool[0], 1'b0);
        push_req(qtab_pkg::REQ_REGISTER,   key_pool[0], 1'b1);
        push_req(qtab_pkg::REQ_CHECK,      key_pool[0], 1'b0);
        push_req(qtab_pkg::REQ_CHECK,      key_pool[0], 1'b1);
        push_req(qtab_pkg::REQ_COUNT,      key_pool[0], 1'b1);
        push_req(qtab_pkg::REQ_UNREGISTER, key_pool[0], 1'b1);
        push_req(qtab_pkg::REQ_UNREGISTER, key_pool[0], 1'b0);
        push_req(qtab_pkg::REQ_UNREGISTER, key_pool[0], 1'b0);
        push_req(qtab_pkg::REQ_COUNT,      key_pool[0], 1'b0);
        push_req(qtab_pkg::REQ_REGISTER,   key_pool[1], 1'b0);
        push_req(qtab_pkg::REQ_COUNT,      key_pool[1], 1'b0);
        push_req(qtab_pkg::REQ_REGISTER,   key_pool[1], 1'b0);
        push_req(qtab_pkg::REQ_REGISTER,   key_pool[2], 1'b1);
        push_req(qtab_pkg::REQ_CHECK,      key_pool[3], 1'b0);
        push_req(qtab_pkg::REQ_UNREGISTER, key_pool[3], 1'b0);
        push_req(qtab_pkg::REQ_COUNT,      32'h1234_5678, 1'b0);
        wait_drained();

        // random phases over several limits, some with no idling
        for (int p = 0; p < 7; p++) begin
            set_limit(limits[p]);
            calm     = (p % 3 == 2);
            hot_base = (p * 5) % (POOL_SIZE - HOT_SIZE);
            push_random(PHASE_ITEMS);
            wait_drained();
        end

        // fill the table with fresh users, then run into the full table
        set_limit(32'd0);
        calm = 1'b0;
        for (int i = 0; i < 75; i++) begin
            fresh = $urandom;
            push_req(qtab_pkg::REQ_REGISTER, fresh, 1'($urandom_range(0, 1)));
            if (i % 5 == 0)
                push_req(qtab_pkg::REQ_COUNT, fresh, 1'b0);
            if (i % 7 == 0)
                push_req(qtab_pkg::REQ_CHECK, $urandom, 1'b0);
        end
        wait_drained();

        set_limit(32'd4);
        hot_base = 0;
        push_random(150);
        wait_drained();
        repeat (80) @(negedge clk);

        users = 0;
        for (int i = 0; i < qtab_pkg::USER_ENTRIES; i++)
            if (user_live[i])
                users = users + 1;
        $display("covered %0d check, %0d register, %0d unregister, %0d count items",
                 req_seen[qtab_pkg::REQ_CHECK], req_seen[qtab_pkg::REQ_REGISTER],
                 req_seen[qtab_pkg::REQ_UNREGISTER], req_seen[qtab_pkg::REQ_COUNT]);
        $display("%0d limits; ok %0d, over %0d, zero %0d, unknown %0d, full %0d; %0d users",
                 limit_settings, status_seen[qtab_pkg::ST_OK], status_seen[qtab_pkg::ST_LIMIT],
                 status_seen[qtab_pkg::ST_ZERO], status_seen[qtab_pkg::ST_UNKNOWN],
                 status_seen[qtab_pkg::ST_FULL], users);
        if (fails == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
